### rtl/csfd_pkg.sv
// Package for the controller status frame decoder: byte and opcode codes,
// record codes, the record descriptor type and the per-opcode record table.
// Used by controller_status_frame_decoder_unit; depends on nothing else.
package csfd_pkg;

  // Frame delimiters.
  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  // Frame opcodes (frame byte 1).
  localparam logic [7:0] OP_MODEL     = 8'h07;
  localparam logic [7:0] OP_LIMITS    = 8'h08;
  localparam logic [7:0] OP_STATUS    = 8'h11;
  localparam logic [7:0] OP_FIRMWARE  = 8'h34;
  localparam logic [7:0] OP_START_TMR = 8'h50;
  localparam logic [7:0] OP_FEED_TMR  = 8'h51;
  localparam logic [7:0] OP_SHUT_TMR  = 8'h52;
  localparam logic [7:0] OP_COOK_TIME = 8'h53;

  // Machine state codes that own a countdown timer.
  localparam logic [7:0] MSC_STARTUP  = 8'd0;
  localparam logic [7:0] MSC_FEED     = 8'd3;
  localparam logic [7:0] MSC_SHUTDOWN = 8'd4;

  // Highest frame byte the decoder ever reads.
  localparam int unsigned STORE_TOP     = 42;
  // The snapshot keeps payload bytes 0..19, which hold every digit group, and
  // then the single status bytes at payload 25, 28, 29, 30, 34, 35, 38, 39, 40.
  localparam int unsigned SNAP_TOP      = 28;
  localparam int unsigned SNAP_IDX_W    = 5;
  // Frame byte that carries the machine state code in a status frame.
  localparam int unsigned STATE_FRM_POS = 28;

  // Width of a decimal group of up to four digit bytes.
  localparam int unsigned DIG_W   = 19;
  localparam int unsigned VALUE_W = 27;

  // Record codes as they leave the block.
  typedef enum logic [4:0] {
    ITEM_MODEL       = 5'd0,
    ITEM_MIN_PIT     = 5'd1,
    ITEM_MAX_PIT     = 5'd2,
    ITEM_FEED_TIME   = 5'd3,
    ITEM_UNKNOWN_A   = 5'd4,
    ITEM_UNKNOWN_B   = 5'd5,
    ITEM_SHUT_TIME   = 5'd6,
    ITEM_STATE       = 5'd7,
    ITEM_PIT         = 5'd8,
    ITEM_SET         = 5'd9,
    ITEM_PROBE1      = 5'd10,
    ITEM_PROBE2      = 5'd11,
    ITEM_SMOKE       = 5'd12,
    ITEM_RTD_ERR     = 5'd13,
    ITEM_OVER_TEMP   = 5'd14,
    ITEM_FLAME_OUT   = 5'd15,
    ITEM_PROBE1_OK   = 5'd16,
    ITEM_PROBE2_OK   = 5'd17,
    ITEM_AUGER       = 5'd18,
    ITEM_FAN         = 5'd19,
    ITEM_IGNITER     = 5'd20,
    ITEM_ACTIVE_TMR  = 5'd21,
    ITEM_START_TMR   = 5'd22,
    ITEM_FEED_TMR    = 5'd23,
    ITEM_SHUT_TMR    = 5'd24,
    ITEM_COOK_TIME   = 5'd25,
    ITEM_UNKNOWN_OP  = 5'd26
  } item_e;

  // Kind of frame held for record emission.
  typedef enum logic [2:0] {
    CLS_MODEL,
    CLS_LIMITS,
    CLS_STATUS,
    CLS_TIMER,
    CLS_COOK,
    CLS_UNKNOWN
  } cls_e;

  // Where a record's value comes from.
  typedef enum logic [2:0] {
    SRC_DIGITS,
    SRC_ZERO,
    SRC_STATE,
    SRC_COOK,
    SRC_OPCODE
  } src_e;

  typedef struct packed {
    item_e                  item;
    src_e                   src;
    logic [SNAP_IDX_W-1:0]  off;
    logic [2:0]             ndig;
  } rec_t;

  // Frame byte held in snapshot slot i.
  function automatic int unsigned snap_src(int unsigned i);
    int unsigned pos;
    case (i)
      20:      pos = 27;
      21:      pos = 30;
      22:      pos = 31;
      23:      pos = 32;
      24:      pos = 36;
      25:      pos = 37;
      26:      pos = 40;
      27:      pos = 41;
      28:      pos = 42;
      default: pos = i + 2;
    endcase
    return pos;
  endfunction

  // Record table: the record at position idx of a frame of kind cls.
  // Status frames start at position 1 unless the active countdown is cleared.
  function automatic rec_t rec_desc(cls_e cls, logic [3:0] idx, item_e titem);
    rec_t r;
    r = '{ITEM_UNKNOWN_OP, SRC_OPCODE, 5'd0, 3'd0};
    case (cls)
      CLS_MODEL: begin
        r = '{ITEM_MODEL, SRC_DIGITS, 5'd0, 3'd1};
      end
      CLS_LIMITS: begin
        case (idx)
          4'd0:    r = '{ITEM_MIN_PIT,   SRC_DIGITS, 5'd0,  3'd3};
          4'd1:    r = '{ITEM_MAX_PIT,   SRC_DIGITS, 5'd3,  3'd3};
          4'd2:    r = '{ITEM_FEED_TIME, SRC_DIGITS, 5'd6,  3'd3};
          4'd3:    r = '{ITEM_UNKNOWN_A, SRC_DIGITS, 5'd9,  3'd3};
          4'd4:    r = '{ITEM_UNKNOWN_B, SRC_DIGITS, 5'd12, 3'd4};
          default: r = '{ITEM_SHUT_TIME, SRC_DIGITS, 5'd16, 3'd4};
        endcase
      end
      CLS_STATUS: begin
        case (idx)
          4'd0:    r = '{ITEM_ACTIVE_TMR, SRC_ZERO,   5'd0,  3'd0};
          4'd1:    r = '{ITEM_STATE,      SRC_STATE,  5'd0,  3'd0};
          4'd2:    r = '{ITEM_PIT,        SRC_DIGITS, 5'd0,  3'd3};
          4'd3:    r = '{ITEM_SET,        SRC_DIGITS, 5'd3,  3'd3};
          4'd4:    r = '{ITEM_PROBE1,     SRC_DIGITS, 5'd12, 3'd3};
          4'd5:    r = '{ITEM_PROBE2,     SRC_DIGITS, 5'd15, 3'd3};
          4'd6:    r = '{ITEM_SMOKE,      SRC_DIGITS, 5'd20, 3'd1};
          4'd7:    r = '{ITEM_RTD_ERR,    SRC_DIGITS, 5'd21, 3'd1};
          4'd8:    r = '{ITEM_OVER_TEMP,  SRC_DIGITS, 5'd22, 3'd1};
          4'd9:    r = '{ITEM_FLAME_OUT,  SRC_DIGITS, 5'd23, 3'd1};
          4'd10:   r = '{ITEM_PROBE1_OK,  SRC_DIGITS, 5'd24, 3'd1};
          4'd11:   r = '{ITEM_PROBE2_OK,  SRC_DIGITS, 5'd25, 3'd1};
          4'd12:   r = '{ITEM_AUGER,      SRC_DIGITS, 5'd26, 3'd1};
          4'd13:   r = '{ITEM_FAN,        SRC_DIGITS, 5'd28, 3'd1};
          default: r = '{ITEM_IGNITER,    SRC_DIGITS, 5'd27, 3'd1};
        endcase
      end
      CLS_TIMER: begin
        if (idx == 4'd0) begin
          r = '{titem, SRC_DIGITS, 5'd0, 3'd4};
        end else begin
          r = '{ITEM_ACTIVE_TMR, SRC_DIGITS, 5'd0, 3'd4};
        end
      end
      CLS_COOK: begin
        r = '{ITEM_COOK_TIME, SRC_COOK, 5'd0, 3'd0};
      end
      default: begin
        r = '{ITEM_UNKNOWN_OP, SRC_OPCODE, 5'd0, 3'd0};
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/controller_status_frame_decoder_unit.sv
// Controller status frame decoder: takes one received byte per item, collects
// frames between a start and an end byte, and emits the decoded records.
// Records: the end byte loads the record sequencer, which then fills the output
// register with the first record; the rest follow one per cycle while the output is not stalled.
// Throughput: one byte per cycle. An end byte waits while the record sequencer
// still drains the previous frame (up to fifteen records), set by its one
// output register. Reset (asynchronous, active low) returns to hunting, with
// state code zero and no records pending; the frame bytes are not cleared.
// Depends on csfd_pkg.
module controller_status_frame_decoder_unit #(
  parameter int unsigned FRAME_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  item_o,
  output logic [26:0] value_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);

  // Receive side state.
  logic             in_frame_q;
  logic [CNT_W-1:0] byte_count_q;
  logic [7:0]       frame_q [1:csfd_pkg::STORE_TOP];
  logic [7:0]       frame_vis [1:csfd_pkg::STORE_TOP];
  logic [7:0]       msc_q;

  // Snapshot of a finished frame and the record sequencer.
  logic [7:0]       snap_q [0:csfd_pkg::SNAP_TOP];
  logic [7:0]       op_q;
  csfd_pkg::cls_e   cls_q;
  csfd_pkg::item_e  titem_q;
  logic             busy_q;
  logic [3:0]       step_q;
  logic [3:0]       end_q;

  // Output register.
  logic                          out_valid_q;
  logic [4:0]                    item_q;
  logic [csfd_pkg::VALUE_W-1:0]  value_q;
  logic                          last_q;

  logic             in_acc;
  logic             is_end;
  logic             store_en;
  logic             overflow;
  logic             decode_go;
  logic             adv;
  logic             rec_last;

  // Decode results for a closing frame.
  logic             dec_has;
  csfd_pkg::cls_e   dec_cls;
  csfd_pkg::item_e  dec_titem;
  logic [3:0]       dec_start;
  logic [3:0]       dec_end;
  logic [7:0]       dec_msc;
  logic [7:0]       dec_op;

  csfd_pkg::rec_t                  rec;
  logic [csfd_pkg::DIG_W-1:0]      dig;
  logic [csfd_pkg::SNAP_IDX_W-1:0] dig_idx;
  logic [14:0]                     cook_h;
  logic [11:0]                     cook_m;
  logic [11:0]                     cook_s;
  logic [csfd_pkg::VALUE_W-1:0]    cook;
  logic [csfd_pkg::VALUE_W-1:0]    rec_value;

  // Handshake. Only an end byte has to wait for the sequencer to drain.
  assign is_end     = (rx_byte_i == csfd_pkg::END_BYTE);
  assign in_stall_o = busy_q & in_frame_q & is_end;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign store_en   = in_acc & in_frame_q & ~is_end & (byte_count_q < CNT_W'(FRAME_BYTES));
  assign overflow   = in_acc & in_frame_q & ~is_end & (byte_count_q >= CNT_W'(FRAME_BYTES));
  assign decode_go  = in_acc & in_frame_q & is_end;

  // Positions that were never received in this frame read as zero.
  always_comb begin
    for (int i = 1; i <= int'(csfd_pkg::STORE_TOP); i++) begin
      frame_vis[i] = (CNT_W'(i) < byte_count_q) ? frame_q[i] : 8'd0;
    end
  end

  // Frame classification when the end byte arrives.
  always_comb begin
    dec_op    = frame_vis[1];
    dec_has   = 1'b1;
    dec_cls   = csfd_pkg::CLS_UNKNOWN;
    dec_titem = csfd_pkg::ITEM_START_TMR;
    dec_start = 4'd0;
    dec_end   = 4'd0;
    dec_msc   = msc_q;
    case (dec_op)
      csfd_pkg::OP_MODEL: begin
        dec_cls = csfd_pkg::CLS_MODEL;
      end
      csfd_pkg::OP_LIMITS: begin
        dec_cls = csfd_pkg::CLS_LIMITS;
        dec_end = 4'd5;
      end
      csfd_pkg::OP_STATUS: begin
        dec_cls = csfd_pkg::CLS_STATUS;
        dec_msc = frame_vis[csfd_pkg::STATE_FRM_POS];
        dec_end = 4'd14;
        // The active countdown is only cleared outside the timed states.
        if (dec_msc == csfd_pkg::MSC_STARTUP || dec_msc == csfd_pkg::MSC_FEED ||
            dec_msc == csfd_pkg::MSC_SHUTDOWN) begin
          dec_start = 4'd1;
        end
      end
      csfd_pkg::OP_FIRMWARE: begin
        dec_has = 1'b0;
      end
      csfd_pkg::OP_START_TMR: begin
        dec_cls   = csfd_pkg::CLS_TIMER;
        dec_titem = csfd_pkg::ITEM_START_TMR;
        dec_end   = (msc_q == csfd_pkg::MSC_STARTUP) ? 4'd1 : 4'd0;
      end
      csfd_pkg::OP_FEED_TMR: begin
        dec_cls   = csfd_pkg::CLS_TIMER;
        dec_titem = csfd_pkg::ITEM_FEED_TMR;
        dec_end   = (msc_q == csfd_pkg::MSC_FEED) ? 4'd1 : 4'd0;
      end
      csfd_pkg::OP_SHUT_TMR: begin
        dec_cls   = csfd_pkg::CLS_TIMER;
        dec_titem = csfd_pkg::ITEM_SHUT_TMR;
        dec_end   = (msc_q == csfd_pkg::MSC_SHUTDOWN) ? 4'd1 : 4'd0;
      end
      csfd_pkg::OP_COOK_TIME: begin
        dec_cls = csfd_pkg::CLS_COOK;
      end
      default: begin
        dec_cls = csfd_pkg::CLS_UNKNOWN;
      end
    endcase
  end

  // Current record and its value.
  assign rec = csfd_pkg::rec_desc(cls_q, step_q, titem_q);

  always_comb begin
    dig     = '0;
    dig_idx = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < rec.ndig) begin
        dig_idx = rec.off + csfd_pkg::SNAP_IDX_W'(k);
        dig     = csfd_pkg::DIG_W'(dig * csfd_pkg::DIG_W'(10))
                + csfd_pkg::DIG_W'((dig_idx <= csfd_pkg::SNAP_IDX_W'(csfd_pkg::SNAP_TOP))
                                   ? snap_q[dig_idx] : 8'd0);
      end
    end
  end

  // Cook time in seconds from fixed hour, minute and second digit groups.
  always_comb begin
    cook_h = 15'(snap_q[0]) * 15'd100 + 15'(snap_q[1]) * 15'd10 + 15'(snap_q[2]);
    cook_m = 12'(snap_q[3]) * 12'd10 + 12'(snap_q[4]);
    cook_s = 12'(snap_q[5]) * 12'd10 + 12'(snap_q[6]);
    cook   = csfd_pkg::VALUE_W'(cook_h) * csfd_pkg::VALUE_W'(3600)
           + csfd_pkg::VALUE_W'(cook_m) * csfd_pkg::VALUE_W'(60)
           + csfd_pkg::VALUE_W'(cook_s);
  end

  always_comb begin
    case (rec.src)
      csfd_pkg::SRC_DIGITS: rec_value = csfd_pkg::VALUE_W'(dig);
      csfd_pkg::SRC_STATE:  rec_value = csfd_pkg::VALUE_W'(msc_q);
      csfd_pkg::SRC_COOK:   rec_value = cook;
      csfd_pkg::SRC_OPCODE: rec_value = csfd_pkg::VALUE_W'(op_q);
      default:              rec_value = '0;
    endcase
  end

  // The sequencer moves on whenever the output register is free or being taken.
  assign adv      = busy_q & (~out_valid_q | ~out_stall_i);
  assign rec_last = (step_q == end_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      byte_count_q <= '0;
      msc_q        <= csfd_pkg::MSC_STARTUP;
      busy_q       <= 1'b0;
      step_q       <= '0;
      end_q        <= '0;
      cls_q        <= csfd_pkg::CLS_UNKNOWN;
      titem_q      <= csfd_pkg::ITEM_START_TMR;
      out_valid_q  <= 1'b0;
    end else begin
      // Frame hunting and counting.
      if (in_acc) begin
        if (!in_frame_q || overflow) begin
          if (rx_byte_i == csfd_pkg::START_BYTE) begin
            in_frame_q   <= 1'b1;
            byte_count_q <= CNT_W'(1);
          end else begin
            in_frame_q   <= 1'b0;
            byte_count_q <= '0;
          end
        end else if (is_end) begin
          in_frame_q   <= 1'b0;
          byte_count_q <= '0;
        end else begin
          byte_count_q <= byte_count_q + CNT_W'(1);
        end
      end

      // Record sequencer.
      if (decode_go) begin
        msc_q   <= dec_msc;
        busy_q  <= dec_has;
        step_q  <= dec_start;
        end_q   <= dec_end;
        cls_q   <= dec_cls;
        titem_q <= dec_titem;
      end else if (adv) begin
        step_q <= step_q + 4'd1;
        if (rec_last) begin
          busy_q <= 1'b0;
        end
      end

      // Output register valid.
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame bytes, snapshot and output payload.
  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= int'(csfd_pkg::STORE_TOP); i++) begin
      if (store_en && byte_count_q == CNT_W'(i)) begin
        frame_q[i] <= rx_byte_i;
      end
    end
    if (decode_go) begin
      op_q <= dec_op;
      for (int i = 0; i <= int'(csfd_pkg::SNAP_TOP); i++) begin
        snap_q[i] <= frame_vis[csfd_pkg::snap_src(i)];
      end
    end
    if (adv) begin
      item_q  <= 5'(rec.item);
      value_q <= rec_value;
      last_q  <= rec_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_o      = item_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  // The sequencer never runs past the last record of its frame.
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= end_q))
    else $error("record step beyond the last record of the frame");

  // A record that is not the last one leaves more records pending.
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> busy_q)
    else $error("non-final record shown with no records pending");

  // The byte count is non-zero exactly while a frame is open.
  a_count_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q == (byte_count_q != '0))
    else $error("byte count disagrees with frame state");

  // Emitting the last record frees the sequencer.
  a_seq_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && rec_last) |=> !busy_q)
    else $error("sequencer still busy after its last record");

endmodule

### dv/controller_status_frame_decoder_unit_tb.sv
// Self-checking testbench for controller_status_frame_decoder_unit: streams serial
// bytes in, predicts every decoded record and compares the records that come out.
// Depends on csfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module controller_status_frame_decoder_unit_tb;

  localparam int unsigned NBYTES    = 64;
  localparam time         HALF_CLK  = 6ns;
  localparam time         RUN_LIMIT = 3_000_000ns;
  localparam int unsigned HOLD_LEN  = 400;
  localparam int unsigned SETTLE    = 24;

  // One decoded record as it should leave the block.
  typedef struct {
    csfd_pkg::item_e item;
    logic [26:0]     value;
    logic            last;
  } record_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [4:0]  item_o;
  logic [26:0] value_o;
  logic        last_o;

  // Stimulus and checking state.
  logic [7:0]  tx_bytes[$];
  int unsigned bytes_queued = 0;
  record_t     records_due[$];
  record_t     frame_recs[$];
  int unsigned mismatches   = 0;
  logic        in_taken     = 1'b0;
  int unsigned send_idle    = 0;
  int unsigned recv_idle    = 0;
  int unsigned hold_reqs    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_cnt     = 0;

  // Shadow copy of the decoder state.
  logic        in_frame_m   = 1'b0;
  int unsigned count_m      = 0;
  logic [7:0]  store_m[NBYTES];
  logic [7:0]  state_m      = csfd_pkg::MSC_STARTUP;

  // Directed opening sequence.
  logic [7:0]  directed[28] = '{
    8'h00, csfd_pkg::END_BYTE,                                    // noise while hunting
    csfd_pkg::START_BYTE, csfd_pkg::END_BYTE,                     // empty frame, opcode zero
    csfd_pkg::START_BYTE, csfd_pkg::OP_MODEL, csfd_pkg::END_BYTE, // short frame reads as zero
    csfd_pkg::START_BYTE, csfd_pkg::OP_MODEL, csfd_pkg::START_BYTE,
    csfd_pkg::END_BYTE,                                           // start byte kept as data
    csfd_pkg::START_BYTE, csfd_pkg::OP_FIRMWARE, 8'h05,
    csfd_pkg::END_BYTE,                                           // firmware gives nothing
    csfd_pkg::START_BYTE, csfd_pkg::START_BYTE, csfd_pkg::END_BYTE, // unknown opcode
    csfd_pkg::START_BYTE, csfd_pkg::OP_COOK_TIME, 8'h09, 8'h09, 8'h09, 8'h05, 8'h09, 8'h05,
    8'h09, csfd_pkg::END_BYTE
  };

  controller_status_frame_decoder_unit #(
    .FRAME_BYTES(NBYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .item_o     (item_o),
    .value_o    (value_o),
    .last_o     (last_o)
  );

  always #(HALF_CLK) clk_i = ~clk_i;

  // Prints one line per mismatch and keeps the tally.
  task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("mismatch: %s expected %0d got %0d", what, want, got);
  endtask

  // Frame byte as the decoder sees it: positions not yet received read as zero.
  function automatic logic [31:0] frame_at(int unsigned idx);
    if (idx < count_m && idx < NBYTES) begin
      return {24'd0, store_m[idx]};
    end
    return 32'd0;
  endfunction

  // Decimal group of n payload bytes, most significant first.
  function automatic logic [31:0] digit_group(int unsigned off, int unsigned n);
    logic [31:0] v;
    v = 32'd0;
    for (int unsigned i = 0; i < n; i++) begin
      v = v * 32'd10 + frame_at(2 + off + i);
    end
    return v;
  endfunction

  task automatic emit_rec(csfd_pkg::item_e it, logic [31:0] v);
    record_t r;
    r.item  = it;
    r.value = v[26:0];
    r.last  = 1'b0;
    if (frame_recs.size() < 15) begin
      frame_recs = {frame_recs, r};
    end
  endtask

  task automatic open_on_start(logic [7:0] b);
    if (b == csfd_pkg::START_BYTE) begin
      in_frame_m = 1'b1;
      store_m[0] = b;
      count_m    = 1;
    end
  endtask

  // Works out the records caused by one accepted byte.
  task automatic decode_rx_byte(logic [7:0] b);
    logic [7:0]  op;
    logic [31:0] t;
    frame_recs.delete();
    if (!in_frame_m) begin
      open_on_start(b);
    end else if (b == csfd_pkg::END_BYTE) begin
      op = 8'(frame_at(1));
      case (op)
        csfd_pkg::OP_MODEL: begin
          emit_rec(csfd_pkg::ITEM_MODEL, frame_at(2));
        end
        csfd_pkg::OP_LIMITS: begin
          emit_rec(csfd_pkg::ITEM_MIN_PIT, digit_group(0, 3));
          emit_rec(csfd_pkg::ITEM_MAX_PIT, digit_group(3, 3));
          emit_rec(csfd_pkg::ITEM_FEED_TIME, digit_group(6, 3));
          emit_rec(csfd_pkg::ITEM_UNKNOWN_A, digit_group(9, 3));
          emit_rec(csfd_pkg::ITEM_UNKNOWN_B, digit_group(12, 4));
          emit_rec(csfd_pkg::ITEM_SHUT_TIME, digit_group(16, 4));
        end
        csfd_pkg::OP_STATUS: begin
          state_m = 8'(frame_at(csfd_pkg::STATE_FRM_POS));
          if (state_m != csfd_pkg::MSC_STARTUP && state_m != csfd_pkg::MSC_FEED &&
              state_m != csfd_pkg::MSC_SHUTDOWN) begin
            emit_rec(csfd_pkg::ITEM_ACTIVE_TMR, 32'd0);
          end
          emit_rec(csfd_pkg::ITEM_STATE, {24'd0, state_m});
          emit_rec(csfd_pkg::ITEM_PIT, digit_group(0, 3));
          emit_rec(csfd_pkg::ITEM_SET, digit_group(3, 3));
          emit_rec(csfd_pkg::ITEM_PROBE1, digit_group(12, 3));
          emit_rec(csfd_pkg::ITEM_PROBE2, digit_group(15, 3));
          emit_rec(csfd_pkg::ITEM_SMOKE, frame_at(2 + 25));
          emit_rec(csfd_pkg::ITEM_RTD_ERR, frame_at(2 + 28));
          emit_rec(csfd_pkg::ITEM_OVER_TEMP, frame_at(2 + 29));
          emit_rec(csfd_pkg::ITEM_FLAME_OUT, frame_at(2 + 30));
          emit_rec(csfd_pkg::ITEM_PROBE1_OK, frame_at(2 + 34));
          emit_rec(csfd_pkg::ITEM_PROBE2_OK, frame_at(2 + 35));
          emit_rec(csfd_pkg::ITEM_AUGER, frame_at(2 + 38));
          emit_rec(csfd_pkg::ITEM_FAN, frame_at(2 + 40));
          emit_rec(csfd_pkg::ITEM_IGNITER, frame_at(2 + 39));
        end
        csfd_pkg::OP_FIRMWARE: begin
        end
        csfd_pkg::OP_START_TMR, csfd_pkg::OP_FEED_TMR, csfd_pkg::OP_SHUT_TMR: begin
          t = digit_group(0, 4);
          if (op == csfd_pkg::OP_START_TMR) begin
            emit_rec(csfd_pkg::ITEM_START_TMR, t);
            if (state_m == csfd_pkg::MSC_STARTUP) emit_rec(csfd_pkg::ITEM_ACTIVE_TMR, t);
          end else if (op == csfd_pkg::OP_FEED_TMR) begin
            emit_rec(csfd_pkg::ITEM_FEED_TMR, t);
            if (state_m == csfd_pkg::MSC_FEED) emit_rec(csfd_pkg::ITEM_ACTIVE_TMR, t);
          end else begin
            emit_rec(csfd_pkg::ITEM_SHUT_TMR, t);
            if (state_m == csfd_pkg::MSC_SHUTDOWN) emit_rec(csfd_pkg::ITEM_ACTIVE_TMR, t);
          end
        end
        csfd_pkg::OP_COOK_TIME: begin
          emit_rec(csfd_pkg::ITEM_COOK_TIME,
                   digit_group(0, 3) * 32'd3600 + digit_group(3, 2) * 32'd60
                   + digit_group(5, 2));
        end
        default: begin
          emit_rec(csfd_pkg::ITEM_UNKNOWN_OP, {24'd0, op});
        end
      endcase
      in_frame_m = 1'b0;
      count_m    = 0;
      if (frame_recs.size() > 0) begin
        frame_recs[frame_recs.size() - 1].last = 1'b1;
      end
      records_due = {records_due, frame_recs};
    end else if (count_m < NBYTES) begin
      store_m[count_m] = b;
      count_m++;
    end else begin
      // An overlong frame is dropped and the byte is taken as a hunting byte.
      in_frame_m = 1'b0;
      count_m    = 0;
      open_on_start(b);
    end
  endtask

  // Sender: a new byte is offered only once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (tx_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        rx_byte_i  <= tx_bytes.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen   <= hold_reqs;
      hold_cnt    <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Monitor: checks each record taken and predicts from each byte taken.
  always @(posedge clk_i) begin
    record_t want;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (records_due.size() == 0) begin
          flag_mismatch("unexpected record, item", 0, item_o);
        end else begin
          want = records_due.pop_front();
          if (item_o != want.item) flag_mismatch("item", want.item, item_o);
          if (value_o != want.value) flag_mismatch("value", want.value, value_o);
          if (last_o != want.last) flag_mismatch("last", want.last, last_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        decode_rx_byte(rx_byte_i);
      end
    end
  end

  task automatic push_byte(logic [7:0] b);
    tx_bytes = {tx_bytes, b};
    bytes_queued++;
  endtask

  // Mostly decimal digits, now and then any byte but the end byte.
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 9) < 8) begin
      return 8'($urandom_range(0, 9));
    end
    return 8'($urandom_range(0, 254));
  endfunction

  // State code for a status frame, biased towards the ones owning a countdown.
  function automatic logic [7:0] state_pick();
    case ($urandom_range(0, 3))
      0:       return csfd_pkg::MSC_STARTUP;
      1:       return csfd_pkg::MSC_FEED;
      2:       return csfd_pkg::MSC_SHUTDOWN;
      default: return 8'($urandom_range(0, 254));
    endcase
  endfunction

  task automatic queue_frame(logic [7:0] op, int unsigned plen);
    push_byte(csfd_pkg::START_BYTE);
    push_byte(op);
    for (int unsigned i = 0; i < plen; i++) begin
      push_byte((op == csfd_pkg::OP_STATUS && i == 26) ? state_pick() : payload_byte());
    end
    push_byte(csfd_pkg::END_BYTE);
  endtask

  // Fills the store, then sends one byte too many; sometimes a start byte.
  task automatic queue_overlong();
    push_byte(csfd_pkg::START_BYTE);
    repeat (NBYTES - 1) push_byte(payload_byte());
    push_byte($urandom_range(0, 1) ? csfd_pkg::START_BYTE : payload_byte());
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned need;
    int unsigned plen;
    logic [7:0]  op;
    pick = $urandom_range(0, 99);
    need = 0;
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    end else if (pick >= 96) begin
      queue_overlong();
    end else begin
      if (pick < 20) begin
        op = csfd_pkg::OP_MODEL;
        need = 1;
      end else if (pick < 30) begin
        op = csfd_pkg::OP_LIMITS;
        need = 20;
      end else if (pick < 46) begin
        op = csfd_pkg::OP_STATUS;
        need = 41;
      end else if (pick < 70) begin
        case ($urandom_range(0, 2))
          0:       op = csfd_pkg::OP_START_TMR;
          1:       op = csfd_pkg::OP_FEED_TMR;
          default: op = csfd_pkg::OP_SHUT_TMR;
        endcase
        need = 4;
      end else if (pick < 80) begin
        op = csfd_pkg::OP_COOK_TIME;
        need = 7;
      end else if (pick < 85) begin
        op = csfd_pkg::OP_FIRMWARE;
        need = $urandom_range(0, 8);
      end else begin
        op = 8'($urandom_range(0, 254));
        need = $urandom_range(0, 4);
      end
      case ($urandom_range(0, 7))
        0:       plen = (need > 0) ? $urandom_range(0, need - 1) : 0;
        1:       plen = need + $urandom_range(1, 5);
        default: plen = need;
      endcase
      queue_frame(op, plen);
    end
  endtask

  task automatic queue_random(int unsigned budget);
    int unsigned target;
    target = bytes_queued + budget;
    while (bytes_queued < target) queue_random_frame();
  endtask

  // Sender pause: all bytes taken and every record out, then a settle time.
  task automatic drain();
    while (tx_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (records_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Run limit.
  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender mostly busy, receiver mostly stalled.
    send_idle = 11;
    recv_idle = 88;
    foreach (directed[i]) push_byte(directed[i]);
    queue_random(70);
    drain();

    // Sender mostly idle, receiver mostly ready.
    send_idle = 88;
    recv_idle = 11;
    queue_random(70);
    drain();

    // No idling; a long receiver hold-off lets the block back up.
    send_idle = 0;
    recv_idle = 0;
    hold_reqs++;
    queue_frame(csfd_pkg::OP_STATUS, 41);
    queue_frame(csfd_pkg::OP_START_TMR, 4);
    queue_frame(csfd_pkg::OP_STATUS, 41);
    drain();

    queue_overlong();
    queue_random(20);
    drain();

    if (records_due.size() > 0) begin
      flag_mismatch("records never produced, count", 0, records_due.size());
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
